FILE: rtl/core/line_substring_matcher_top_macros.svh
// Assertion macros for the line substring matcher.
// Used by line_substring_matcher_top; expects clk and arst_n in scope.
`ifndef LINE_SUBSTRING_MATCHER_TOP_MACROS_SVH
`define LINE_SUBSTRING_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LSM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line matcher check failed");

// Next-cycle implication, disabled while in reset
`define LSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line matcher check failed");

`endif

FILE: rtl/core/lsm_pkg.sv
// Shared constants and types for the line substring matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int LINE_MAX    = 2048;
	localparam int KEPT_W      = $clog2(LINE_MAX);
	localparam int LEN_W       = 6;
	localparam int WORD_W      = 64;
	localparam int LINE_W      = 32;
	localparam int CFG_IDX_W   = 3;

	// Special characters
	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAT_A   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_B   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_C   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_D   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd4;

	// Pattern as seen by the cell row; len is already clamped to PATTERN_MAX
	typedef struct packed {
		logic [PATTERN_MAX-1:0][7:0] bytes;
		logic [LEN_W-1:0]            len;
	} pattern_cfg_t;

	// Broadcast to every cell
	typedef struct packed {
		logic       clear;
		logic       step;
		logic [7:0] text;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/lsm_cfg.sv
// Pattern configuration registers of the line substring matcher.
// Depends on lsm_pkg.
`default_nettype none

module lsm_cfg
	import lsm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [WORD_W-1:0]    wr_data,
	output pattern_cfg_t              pattern
);

	logic [3:0][WORD_W-1:0] word_q;
	logic [LEN_W-1:0]       len_q;
	logic [4*WORD_W-1:0]    flat;

	// Write one register per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			len_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PAT_A:   word_q[0] <= wr_data;
				REG_PAT_B:   word_q[1] <= wr_data;
				REG_PAT_C:   word_q[2] <= wr_data;
				REG_PAT_D:   word_q[3] <= wr_data;
				REG_PAT_LEN: len_q <= wr_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Split words into pattern bytes and clamp the length
	assign flat = word_q;

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			pattern.bytes[i] = flat[i*8 +: 8];
		end
		if (len_q > LEN_W'(PATTERN_MAX)) begin
			pattern.len = LEN_W'(PATTERN_MAX);
		end else begin
			pattern.len = len_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/lsm_cell.sv
// One shift-and cell: holds the partial-match bit of one pattern position.
// Depends on lsm_pkg; chained by line_substring_matcher_top.
`default_nettype none

module lsm_cell
	import lsm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire logic [7:0] pat_byte,
	input  wire logic       in_use,
	input  wire logic       left_bit,
	output logic            bit_next,
	output logic            bit_q
);

	// Take the neighbor's bit when this position's byte matches
	assign bit_next = left_bit & in_use & (ctrl.text == pat_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctrl.clear) begin
			bit_q <= 1'b0;
		end else if (ctrl.step) begin
			bit_q <= bit_next;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/line_substring_matcher_top.sv
// Channel   Direction  Handshake            Word
// text      in         text_valid/stall     data_byte, end_of_stream
// hit       out        hit_valid/stall      matching_line, unterminated
// cfg       in         cfg_valid/ready      cfg_index, cfg_data
//
// One text word per cycle unless stalled; each line result is registered.
// The PATTERN_MAX shift-and cells step per searched word, clear at line end.
// Reset clears all line state, sets the line number to one, zeros the pattern.
// A two-entry output buffer lets text flow while one result is stalled;
// text_stall rises only when both entries are full.
// Depends on lsm_pkg, lsm_cfg, lsm_cell and the macros header.
`default_nettype none

`include "line_substring_matcher_top_macros.svh"

module line_substring_matcher_top
	import lsm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 text_valid,
	output logic                      text_stall,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 end_of_stream,
	output logic                      hit_valid,
	input  wire logic                 hit_stall,
	output logic [LINE_W-1:0]         matching_line,
	output logic                      unterminated,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data
);

	pattern_cfg_t            pattern;
	cell_ctrl_t              ctrl;
	logic [PATTERN_MAX-1:0]  bits_q;
	logic [PATTERN_MAX-1:0]  bits_next;
	logic [PATTERN_MAX-1:0]  last_pos;

	logic [KEPT_W-1:0] kept_q;
	logic [LINE_W-1:0] line_count_q;
	logic              line_hit_q;
	logic              cut_q;

	logic accept, is_nl, line_end, keep, search, matched, hit_now, res_v;

	logic              out_valid_q, skid_valid_q;
	logic [LINE_W-1:0] out_line_q, skid_line_q;
	logic              out_unterm_q, skid_unterm_q;
	logic              out_free;

	assign cfg_ready = 1'b1;

	lsm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.pattern  (pattern)
	);

	// Classify the accepted word
	assign accept   = text_valid & ~text_stall;
	assign is_nl    = (data_byte == CHAR_NL);
	assign line_end = accept & (end_of_stream | is_nl);
	assign keep     = accept & ~end_of_stream & ~is_nl & (data_byte != CHAR_CR)
		& (kept_q < KEPT_W'(LINE_MAX - 1));
	assign search   = keep & (data_byte != CHAR_NUL) & ~cut_q & (pattern.len != '0);
	assign matched  = line_hit_q | (pattern.len == '0);
	assign res_v    = accept & matched
		& (end_of_stream ? (kept_q != '0) : is_nl);

	assign ctrl.clear = line_end;
	assign ctrl.step  = search;
	assign ctrl.text  = data_byte;

	// Row of shift-and cells, each fed by its left neighbor
	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic left;
		if (i == 0) begin : g_head
			assign left = 1'b1;
		end else begin : g_link
			assign left = bits_q[i-1];
		end
		assign last_pos[i] = (LEN_W'(i + 1) == pattern.len);
		lsm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.pat_byte (pattern.bytes[i]),
			.in_use   (LEN_W'(i) < pattern.len),
			.left_bit (left),
			.bit_next (bits_next[i]),
			.bit_q    (bits_q[i])
		);
	end

	assign hit_now = |(bits_next & last_pos);

	// Line bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q       <= '0;
			line_count_q <= LINE_W'(1);
			line_hit_q   <= 1'b0;
			cut_q        <= 1'b0;
		end else begin
			if (line_end) begin
				kept_q     <= '0;
				line_hit_q <= 1'b0;
				cut_q      <= 1'b0;
			end else if (keep) begin
				kept_q <= kept_q + KEPT_W'(1);
				if (data_byte == CHAR_NUL) begin
					cut_q <= 1'b1;
				end
				if (search && hit_now) begin
					line_hit_q <= 1'b1;
				end
			end
			if (accept && end_of_stream) begin
				line_count_q <= LINE_W'(1);
			end else if (accept && is_nl) begin
				line_count_q <= line_count_q + LINE_W'(1);
			end
		end
	end

	// Output register with one skid entry behind it
	assign out_free   = ~out_valid_q | ~hit_stall;
	assign text_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | res_v;
			skid_valid_q <= 1'b0;
		end else if (res_v) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_line_q   <= skid_line_q;
				out_unterm_q <= skid_unterm_q;
			end else begin
				out_line_q   <= line_count_q;
				out_unterm_q <= end_of_stream;
			end
		end else if (res_v) begin
			skid_line_q   <= line_count_q;
			skid_unterm_q <= end_of_stream;
		end
	end

	assign hit_valid     = out_valid_q;
	assign matching_line = out_line_q;
	assign unterminated  = out_unterm_q;

	// Checks
	`LSM_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
	`LSM_ASSERT_NEXT(a_eos_restarts, accept && end_of_stream,
		line_count_q == LINE_W'(1) && kept_q == '0 && bits_q == '0)
	`LSM_ASSERT_NEXT(a_nl_clears_line, accept && !end_of_stream && is_nl,
		kept_q == '0 && !line_hit_q && !cut_q && bits_q == '0)

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking bench for line_substring_matcher_top: programs directed and random patterns and streams
// text words, then checks every reported line against a shift-and line predictor or the directed table.
// Depends on lsm_pkg and the block's RTL only.
module testbench;
	import lsm_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE       = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_WORDS = 1550;
	localparam int FINAL_WORDS  = 150;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

	// One step of the directed table: a text word or a register write
	typedef struct {
		row_kind_e            kind;
		logic [7:0]           text;
		logic                 eos;
		bit                   typed;
		bit                   t_hit;
		logic [LINE_W-1:0]    t_line;
		logic                 t_unterm;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [WORD_W-1:0]    reg_val;
	} stim_row_t;

	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic              unterm;
	} line_hit_t;

	logic                 clk;
	logic                 arst_n;
	logic                 text_valid;
	logic                 text_stall;
	logic [7:0]           data_byte;
	logic                 end_of_stream;
	logic                 hit_valid;
	logic                 hit_stall;
	logic [LINE_W-1:0]    matching_line;
	logic                 unterminated;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	// Predictor copy of the pattern registers and the line state
	logic [WORD_W-1:0] pat_word [4];
	logic [LEN_W-1:0]  pat_len_reg;
	logic [31:0]       pm_bits;
	int                kept_n;
	logic [LINE_W-1:0] line_no;
	bit                line_found;
	bit                nul_seen;

	line_hit_t pending_hits [$];
	int        words_sent = 0;
	int        errors = 0;
	int        cycles = 0;
	int        gap_pct;
	int        stall_pct;
	bit        quiet;
	bit        long_hold;

	line_substring_matcher_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_valid    (text_valid),
		.text_stall    (text_stall),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.hit_valid     (hit_valid),
		.hit_stall     (hit_stall),
		.matching_line (matching_line),
		.unterminated  (unterminated),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int pattern_len_used();
		return (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
	endfunction

	function automatic logic [7:0] pattern_byte(input int i);
		return pat_word[i / 8][(i % 8) * 8 +: 8];
	endfunction

	function automatic void clear_line_state();
		pm_bits    = '0;
		kept_n     = 0;
		line_found = 1'b0;
		nul_seen   = 1'b0;
	endfunction

	// Advance the line state by one word; return 1 when the word closes a matching line
	function automatic bit predict_line_hit(input logic [7:0] c, input logic eos,
			output line_hit_t res);
		int          m;
		int          i;
		bit          found;
		logic [31:0] mask;
		logic [31:0] keep;
		m = pattern_len_used();
		found = line_found || (m == 0);
		res.line = line_no;
		res.unterm = eos;
		if (eos) begin
			found = found && (kept_n > 0);
			clear_line_state();
			line_no = 32'd1;
			return found;
		end
		if (c == CHAR_NL) begin
			clear_line_state();
			line_no = line_no + 32'd1;
			return found;
		end
		// keep bytes up to the line limit; carriage returns never count
		if (kept_n < LINE_MAX - 1 && c != CHAR_CR) begin
			kept_n++;
			if (c == CHAR_NUL) begin
				nul_seen = 1'b1;
			end else if (!nul_seen && m != 0) begin
				mask = '0;
				for (i = 0; i < m; i++) begin
					if (pattern_byte(i) == c)
						mask[i] = 1'b1;
				end
				keep = (m >= 32) ? 32'hFFFF_FFFF : ((32'd1 << m) - 32'd1);
				pm_bits = (((pm_bits << 1) | 32'd1) & mask) & keep;
				if (pm_bits[m-1])
					line_found = 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic stim_row_t row_w(input logic [7:0] b, input logic eos);
		return '{ROW_WORD, b, eos, 1'b0, 1'b0, '0, 1'b0, '0, '0};
	endfunction

	function automatic stim_row_t row_t(input logic [7:0] b, input logic eos, input bit hit,
			input logic [LINE_W-1:0] line, input logic unterm);
		return '{ROW_WORD, b, eos, 1'b1, hit, line, unterm, '0, '0};
	endfunction

	function automatic stim_row_t row_r(input logic [CFG_IDX_W-1:0] idx,
			input logic [WORD_W-1:0] val);
		return '{ROW_REG, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b0, idx, val};
	endfunction

	// Mostly a small alphabet so that lines hit; the rest anything
	function automatic logic [8*PATTERN_MAX-1:0] random_pattern();
		logic [8*PATTERN_MAX-1:0] pat;
		int                       i;
		for (i = 0; i < PATTERN_MAX; i++) begin
			if ($urandom_range(0, 99) < 80)
				pat[i*8 +: 8] = 8'($urandom_range(8'h61, 8'h64));
			else
				pat[i*8 +: 8] = 8'($urandom_range(0, 255));
		end
		return pat;
	endfunction

	// Present one word, hold it until taken, then record what it should produce
	task automatic send_word(input stim_row_t r);
		line_hit_t res;
		bit        got;
		@(negedge clk);
		text_valid <= 1'b1;
		data_byte <= r.text;
		end_of_stream <= r.eos;
		do @(posedge clk); while (text_stall);
		got = predict_line_hit(r.text, r.eos, res);
		if (r.typed) begin
			got = r.t_hit;
			res.line = r.t_line;
			res.unterm = r.t_unterm;
		end
		if (got)
			pending_hits.push_back(res);
		words_sent++;
	endtask

	// Drop valid for a random burst now and then
	task automatic pause_text();
		if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			text_valid <= 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	endtask

	task automatic offer_word(input logic [7:0] b, input logic eos);
		pause_text();
		send_word(row_w(b, eos));
	endtask

	// Drain all expected lines and let the pipeline settle
	task automatic quiesce();
		@(negedge clk);
		text_valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PAT_A: pat_word[0] = val;
			REG_PAT_B: pat_word[1] = val;
			REG_PAT_C: pat_word[2] = val;
			REG_PAT_D: pat_word[3] = val;
			REG_PAT_LEN: pat_len_reg = val[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_config();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Program all pattern registers; junk above the length field must be ignored
	task automatic load_pattern(input logic [8*PATTERN_MAX-1:0] pat, input logic [LEN_W-1:0] len);
		logic [WORD_W-1:0] len_word;
		len_word = {$urandom(), $urandom()};
		len_word[LEN_W-1:0] = len;
		quiesce();
		write_reg(REG_PAT_A, pat[0 +: WORD_W]);
		write_reg(REG_PAT_B, pat[WORD_W +: WORD_W]);
		write_reg(REG_PAT_C, pat[2*WORD_W +: WORD_W]);
		write_reg(REG_PAT_D, pat[3*WORD_W +: WORD_W]);
		write_reg(REG_PAT_LEN, len_word);
		end_config();
	endtask

	// Mostly well-formed lines, some with the pattern or a broken copy, plus noise
	task automatic run_text_phase(input int n_words);
		logic [7:0] line_bytes [$];
		int         start;
		int         m;
		int         len;
		int         pos;
		int         copy_n;
		int         sel;
		int         i;
		start = words_sent;
		m = pattern_len_used();
		while (words_sent - start < n_words) begin
			line_bytes.delete();
			if ($urandom_range(0, 99) < 85) begin
				len = $urandom_range(0, 24);
				for (i = 0; i < len; i++) begin
					sel = $urandom_range(0, 99);
					if (sel < 65)
						line_bytes.push_back((m != 0) ? pattern_byte($urandom_range(0, m - 1))
							: 8'($urandom_range(8'h61, 8'h64)));
					else if (sel < 90)
						line_bytes.push_back(8'($urandom_range(0, 255)));
					else if (sel < 95)
						line_bytes.push_back(CHAR_CR);
					else
						line_bytes.push_back(CHAR_NUL);
				end
				if (m != 0 && $urandom_range(0, 1) == 1) begin
					copy_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, m) : m;
					pos = $urandom_range(0, len);
					for (i = 0; i < copy_n; i++)
						line_bytes.insert(pos + i, pattern_byte(i));
				end
				foreach (line_bytes[k])
					offer_word(line_bytes[k], 1'b0);
				if ($urandom_range(0, 99) < 8)
					offer_word(8'($urandom_range(0, 255)), 1'b1);
				else
					offer_word(CHAR_NL, 1'b0);
			end else begin
				len = $urandom_range(1, 20);
				for (i = 0; i < len; i++) begin
					sel = $urandom_range(0, 99);
					if (sel < 25)
						offer_word(CHAR_NL, 1'b0);
					else if (sel < 40)
						offer_word(CHAR_CR, 1'b0);
					else if (sel < 55)
						offer_word(CHAR_NUL, 1'b0);
					else
						offer_word(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
				end
			end
		end
		// leave a line open now and then so the next pattern lands mid-line
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 3)) offer_word(8'($urandom_range(8'h61, 8'h64)), 1'b0);
		end
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin : hit_pace
		int n;
		hit_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				hit_stall <= 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
				hit_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				hit_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				hit_stall <= 1'b0;
			end
		end
	end

	// Compare each taken result word with the oldest expected line
	always @(posedge clk) begin : hit_check
		line_hit_t want;
		if (arst_n && hit_valid && !hit_stall) begin
			if (pending_hits.size() == 0) begin
				errors++;
				$display("%0t: unexpected line report: expected none, got line %0d unterminated %0b",
					$time, matching_line, unterminated);
			end else begin
				want = pending_hits.pop_front();
				if (matching_line !== want.line) begin
					errors++;
					$display("%0t: matching_line expected %0d got %0d",
						$time, want.line, matching_line);
				end
				if (unterminated !== want.unterm) begin
					errors++;
					$display("%0t: unterminated expected %0b got %0b (line %0d)",
						$time, want.unterm, unterminated, want.line);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin : main_seq
		stim_row_t        dir_rows [$];
		bit               in_cfg;
		int               base;
		int               sel;
		int               i;
		logic [LEN_W-1:0] plen;
		arst_n = 1'b0;
		text_valid = 1'b0;
		data_byte = '0;
		end_of_stream = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		long_hold = 1'b0;
		gap_pct = 10;
		stall_pct = 10;
		foreach (pat_word[k])
			pat_word[k] = '0;
		pat_len_reg = '0;
		clear_line_state();
		line_no = 32'd1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		dir_rows = '{
			// empty pattern out of reset: every newline-ended line reports
			row_t(CHAR_NL, 1'b0, 1'b1, 32'd1, 1'b0),
			// end of stream on an empty line: nothing, numbering restarts
			row_t(8'h00, 1'b1, 1'b0, 32'd0, 1'b0),
			row_t(8'hFF, 1'b0, 1'b0, 32'd0, 1'b0),
			row_t(8'h00, 1'b1, 1'b1, 32'd1, 1'b1),
			// a lone carriage return leaves the line empty
			row_t(CHAR_CR, 1'b0, 1'b0, 32'd0, 1'b0),
			row_t(8'hFF, 1'b1, 1'b0, 32'd0, 1'b0),
			// a NUL still makes the line non-empty
			row_t(CHAR_NUL, 1'b0, 1'b0, 32'd0, 1'b0),
			row_t(CHAR_NL, 1'b0, 1'b1, 32'd1, 1'b0),
			row_t(CHAR_NL, 1'b0, 1'b1, 32'd2, 1'b0),
			// pattern "ab"
			row_r(REG_PAT_A, 64'h6261),
			row_r(REG_PAT_LEN, 64'd2),
			row_w("x", 1'b0), row_w("a", 1'b0), row_w("b", 1'b0), row_w(CHAR_NL, 1'b0),
			// NUL hides the rest of the line
			row_w("a", 1'b0), row_w(CHAR_NUL, 1'b0), row_w("b", 1'b0), row_w(CHAR_NL, 1'b0),
			// carriage return between pattern bytes is dropped
			row_w("a", 1'b0), row_w(CHAR_CR, 1'b0), row_w("b", 1'b0), row_w(CHAR_NL, 1'b0),
			// switch to an oversized length in the middle of a line
			row_w("a", 1'b0),
			row_r(REG_PAT_B, 64'hFFFF_FFFF_FFFF_FFFF),
			row_r(REG_PAT_C, 64'hFFFF_FFFF_FFFF_FFFF),
			row_r(REG_PAT_D, 64'hFFFF_FFFF_FFFF_FFFF),
			row_r(REG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFFF),
			row_w("b", 1'b0), row_w(CHAR_NL, 1'b0),
			// pattern holding a NUL can never hit
			row_r(REG_PAT_A, 64'h61),
			row_r(REG_PAT_LEN, 64'd2),
			row_w("a", 1'b0), row_w(CHAR_NUL, 1'b0), row_w(CHAR_NL, 1'b0)
		};
		in_cfg = 1'b0;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_REG) begin
				if (!in_cfg)
					quiesce();
				write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
				in_cfg = 1'b1;
			end else begin
				if (in_cfg) begin
					end_config();
					in_cfg = 1'b0;
				end
				pause_text();
				send_word(dir_rows[r]);
			end
		end

		// Overflow lines: pattern "xyz" ending on the last kept byte, then straddling it
		load_pattern(256'h7A7978, 6'd3);
		for (i = 0; i < LINE_MAX - 4; i++)
			offer_word(".", 1'b0);
		offer_word("x", 1'b0);
		offer_word("y", 1'b0);
		offer_word("z", 1'b0);
		offer_word(CHAR_CR, 1'b0);
		offer_word("q", 1'b0);
		offer_word(CHAR_NL, 1'b0);
		for (i = 0; i < LINE_MAX - 3; i++)
			offer_word(".", 1'b0);
		offer_word("x", 1'b0);
		offer_word("y", 1'b0);
		offer_word("z", 1'b0);
		offer_word(CHAR_NL, 1'b0);

		// Back-pressure: every line reports while the receiver holds off
		load_pattern('0, '0);
		gap_pct = 0;
		long_hold = 1'b1;
		repeat (150) offer_word(($urandom_range(0, 3) == 0) ? 8'h61 : CHAR_NL, 1'b0);

		// Random phases, each with its own pattern and idling mix
		base = words_sent;
		while (words_sent - base < RANDOM_WORDS) begin
			sel = $urandom_range(0, 99);
			if (sel < 10)
				plen = '0;
			else if (sel < 70)
				plen = LEN_W'($urandom_range(1, 4));
			else if (sel < 85)
				plen = LEN_W'($urandom_range(5, 31));
			else if (sel < 95)
				plen = LEN_W'(PATTERN_MAX);
			else
				plen = LEN_W'($urandom_range(33, 63));
			load_pattern(random_pattern(), plen);
			gap_pct = 10 * $urandom_range(0, 3);
			stall_pct = 10 * $urandom_range(0, 3);
			run_text_phase($urandom_range(40, 160));
		end

		// Closing stretch at full rate
		quiet = 1'b1;
		load_pattern(random_pattern(), LEN_W'($urandom_range(1, 4)));
		run_text_phase(FINAL_WORDS);
		quiesce();

		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
